// ===== design/xed_pkg.sv =====
package xed_pkg;

   // parse modes, the encoding follows the behavioral description
   localparam logic [2:0] MODE_TEXT = 3'd0;
   localparam logic [2:0] MODE_AMP  = 3'd1;
   localparam logic [2:0] MODE_A    = 3'd2;
   localparam logic [2:0] MODE_HASH = 3'd3;
   localparam logic [2:0] MODE_HEX  = 3'd4;
   localparam logic [2:0] MODE_DEC  = 3'd5;
   localparam logic [2:0] MODE_SKIP = 3'd6;

   // ASCII characters used by the decoder
   localparam logic [7:0] CH_AMP    = 8'h26;  // &
   localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;
   localparam logic [7:0] CH_HASH   = 8'h23;  // #
   localparam logic [7:0] CH_APOS   = 8'h27;  // '
   localparam logic [7:0] CH_QUOT   = 8'h22;  // "
   localparam logic [7:0] CH_GT     = 8'h3E;  // >
   localparam logic [7:0] CH_LT     = 8'h3C;  // <
   localparam logic [7:0] CH_LO_A   = 8'h61;  // a
   localparam logic [7:0] CH_LO_G   = 8'h67;  // g
   localparam logic [7:0] CH_LO_L   = 8'h6C;  // l
   localparam logic [7:0] CH_LO_M   = 8'h6D;  // m
   localparam logic [7:0] CH_LO_Q   = 8'h71;  // q
   localparam logic [7:0] CH_LO_X   = 8'h78;  // x
   localparam logic [7:0] CH_UP_X   = 8'h58;  // X
   localparam logic [7:0] CH_UP_A   = 8'h41;  // A
   localparam logic [7:0] CH_UP_Z   = 8'h5A;  // Z
   localparam logic [7:0] CH_ZERO   = 8'h30;  // 0
   localparam logic [7:0] CH_NINE   = 8'h39;  // 9
   localparam logic [7:0] CASE_DIFF = 8'h20;  // 'a' - 'A'
   localparam logic [7:0] TEN       = 8'd10;

   // outcome of one byte: next state plus an optional result beat
   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] acc;
      logic       emit;
      logic [7:0] data;
      logic       ent;
   } step_type;

endpackage

// ===== design/xed_step.sv =====
module xed_step (
   input  logic [2:0]        mode,
   input  logic [7:0]        acc,
   input  logic [7:0]        text_byte,
   input  logic              last,
   output xed_pkg::step_type step
);

   logic [7:0] lowered;
   logic [7:0] hex_val;
   logic [7:0] dec_val;
   logic [7:0] acc_x10;
   logic [7:0] acc_x16;
   logic       is_semi;

   // digit values, all modulo 256
   always_comb begin
      lowered = text_byte;
      if (text_byte >= xed_pkg::CH_UP_A && text_byte <= xed_pkg::CH_UP_Z) begin
         lowered = text_byte + xed_pkg::CASE_DIFF;
      end
      if (lowered >= xed_pkg::CH_ZERO && lowered <= xed_pkg::CH_NINE) begin
         hex_val = lowered - xed_pkg::CH_ZERO;
      end else begin
         hex_val = lowered - xed_pkg::CH_LO_A + xed_pkg::TEN;
      end
      dec_val = text_byte - xed_pkg::CH_ZERO;
   end

   // shift-and-add scaling of the accumulator
   assign acc_x10 = {acc[4:0], 3'b000} + {acc[6:0], 1'b0};
   assign acc_x16 = {acc[3:0], 4'b0000};
   assign is_semi = (text_byte == xed_pkg::CH_SEMI);

   // per-mode decode
   always_comb begin
      step.mode = mode;
      step.acc  = acc;
      step.emit = 1'b0;
      step.data = text_byte;
      step.ent  = 1'b0;
      case (mode)
         xed_pkg::MODE_AMP: begin
            case (text_byte)
               xed_pkg::CH_LO_A: step.mode = xed_pkg::MODE_A;
               xed_pkg::CH_LO_G: begin
                  step.data = xed_pkg::CH_GT;
                  step.ent  = 1'b1;
                  step.emit = 1'b1;
                  step.mode = xed_pkg::MODE_SKIP;
               end
               xed_pkg::CH_LO_L: begin
                  step.data = xed_pkg::CH_LT;
                  step.ent  = 1'b1;
                  step.emit = 1'b1;
                  step.mode = xed_pkg::MODE_SKIP;
               end
               xed_pkg::CH_LO_Q: begin
                  step.data = xed_pkg::CH_QUOT;
                  step.ent  = 1'b1;
                  step.emit = 1'b1;
                  step.mode = xed_pkg::MODE_SKIP;
               end
               xed_pkg::CH_HASH: begin
                  step.acc  = 8'd0;
                  step.mode = xed_pkg::MODE_HASH;
               end
               xed_pkg::CH_SEMI: step.mode = xed_pkg::MODE_TEXT;
               default:          step.mode = xed_pkg::MODE_SKIP;
            endcase
         end
         xed_pkg::MODE_A: begin
            step.data = (text_byte == xed_pkg::CH_LO_M) ? xed_pkg::CH_AMP : xed_pkg::CH_APOS;
            step.ent  = 1'b1;
            step.emit = 1'b1;
            step.mode = is_semi ? xed_pkg::MODE_TEXT : xed_pkg::MODE_SKIP;
         end
         xed_pkg::MODE_HASH: begin
            if (text_byte == xed_pkg::CH_LO_X || text_byte == xed_pkg::CH_UP_X) begin
               step.mode = xed_pkg::MODE_HEX;
            end else if (is_semi) begin
               step.data = acc;
               step.ent  = 1'b1;
               step.emit = 1'b1;
               step.mode = xed_pkg::MODE_TEXT;
            end else begin
               step.acc  = acc_x10 + dec_val;
               step.mode = xed_pkg::MODE_DEC;
            end
         end
         xed_pkg::MODE_HEX, xed_pkg::MODE_DEC: begin
            if (is_semi) begin
               step.data = acc;
               step.ent  = 1'b1;
               step.emit = 1'b1;
               step.mode = xed_pkg::MODE_TEXT;
            end else if (mode == xed_pkg::MODE_HEX) begin
               step.acc = acc_x16 + hex_val;
            end else begin
               step.acc = acc_x10 + dec_val;
            end
         end
         xed_pkg::MODE_SKIP: begin
            if (is_semi) begin
               step.mode = xed_pkg::MODE_TEXT;
            end
         end
         default: begin
            // text mode, and the unused code behaves the same
            if (text_byte == xed_pkg::CH_AMP) begin
               step.mode = xed_pkg::MODE_AMP;
            end else begin
               step.mode = xed_pkg::MODE_TEXT;
               step.emit = 1'b1;
            end
         end
      endcase

      // end of string drops any open entity
      if (last) begin
         step.mode = xed_pkg::MODE_TEXT;
         step.acc  = 8'd0;
      end
   end

endmodule

// ===== design/xml_entity_decoder.sv =====
// Byte-stream XML character entity decoder.
// Input beats on req_* carry one text byte each, with req_tlast marking the
// last byte of a string. Plain bytes pass through; &amp; &apos; &gt; &lt;
// &quot; (chosen by first letter, the second telling &amp; from &apos;) and
// &#ddd; / &#xhh; references are replaced by one decoded byte. Output beats
// on rsp_* carry that byte, with rsp_tuser set when it came from an entity.
// Bytes that are part of an entity and emit nothing produce no output beat.
// Path: a byte accepted into the input register passes through the decode
// logic into the result register and shows on rsp_* from there (one input
// register, one result register); a receiver stall can hold it in between.
// Throughput: one byte per cycle while the receiver does not stall; the mode
// and 8-bit code accumulator step per byte; no gaps in back-to-back beats.
// Reset puts the parser in text mode with a cleared accumulator and empties
// both registers. When the receiver stalls, the result register holds its
// beat; the input register can still take one more byte, after which
// req_tready drops until the stall clears.
module xml_entity_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tlast,   // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] decoded_byte
   output logic       rsp_tuser    // [0] from_entity
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_data_ff;
   logic              out_ent_ff;
   logic [2:0]        mode_ff, mode_in;
   logic [7:0]        acc_ff, acc_in;
   logic              out_ready;
   logic              fire;
   xed_pkg::step_type step;

   // pipeline handshake
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;

   xed_step u_step (
      .mode      (mode_ff),
      .acc       (acc_ff),
      .text_byte (in_byte_ff),
      .last      (in_last_ff),
      .step      (step)
   );

   // next control state
   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (out_ready) begin
         out_valid_in = fire && step.emit;
      end
      if (fire) begin
         mode_in = step.mode;
         acc_in  = step.acc;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= xed_pkg::MODE_TEXT;
         acc_ff       <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         acc_ff       <= acc_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (fire && step.emit) begin
         out_data_ff <= step.data;
         out_ent_ff  <= step.ent;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_ent_ff;

   // reset leaves the parser in text mode
   a_reset_text: assert property (@(posedge clock)
      reset |=> (mode_ff == xed_pkg::MODE_TEXT) && (acc_ff == 8'd0))
      else $error("parser not in text mode after reset");

   // last byte of a string closes any entity
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (fire && in_last_ff) |=> (mode_ff == xed_pkg::MODE_TEXT) && (acc_ff == 8'd0))
      else $error("entity still open after end of string");

   // a decoded byte that emits shows up in the next cycle, otherwise none does
   a_emit_beat: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_tvalid == $past(step.emit)))
      else $error("result beat does not match decode");

   // input side stalls only when both registers are full and held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_tvalid && !rsp_tready))
      else $error("input stalled without a held result");

endmodule
